### hw/rtl/q2r_pkg.sv
`default_nettype none
package q2r_pkg;
  localparam int unsigned IN_W      = 16;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned FRAC_BITS = OUT_W - 2;
  localparam int unsigned PROD_W    = 2 * IN_W;
  localparam int unsigned DEN_W     = PROD_W + 1;
  localparam int unsigned NUM_W     = PROD_W + 2;
  localparam int unsigned DIV_STEPS = FRAC_BITS;
  // input reg, product reg, sum reg, divider steps, rounding reg
  localparam int unsigned LATENCY   = 3 + DIV_STEPS + 1;
  localparam logic [OUT_W-1:0] ONE_Q = OUT_W'(1) << FRAC_BITS;
endpackage
`default_nettype wire

### hw/rtl/q2r_div.sv
`default_nettype none
// Pipelined restoring divider: round(mag * 2^FRAC_BITS / den), one step per stage.
module q2r_div import q2r_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             sat_i,
  input  wire logic             neg_i,
  input  wire logic [NUM_W-1:0] mag_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [OUT_W-1:0] q_o
);
  logic [DEN_W-1:0]     rem_s [DIV_STEPS+1];
  logic [DEN_W-1:0]     den_s [DIV_STEPS+1];
  logic [FRAC_BITS-1:0] quo_s [DIV_STEPS+1];
  logic                 sat_s [DIV_STEPS+1];
  logic                 neg_s [DIV_STEPS+1];

  // mag < den whenever sat is low, so it fits the remainder width
  assign rem_s[0] = mag_i[DEN_W-1:0];
  assign den_s[0] = den_i;
  assign quo_s[0] = '0;
  assign sat_s[0] = sat_i;
  assign neg_s[0] = neg_i;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [DEN_W:0]   sh;
    logic             ge;
    logic [DEN_W-1:0] nxt;
    always_comb begin
      sh  = {rem_s[k], 1'b0};
      ge  = sh >= {1'b0, den_s[k]};
      nxt = ge ? DEN_W'(sh - {1'b0, den_s[k]}) : sh[DEN_W-1:0];
    end
    always_ff @(posedge clk_i) begin
      rem_s[k+1] <= nxt;
      den_s[k+1] <= den_s[k];
      quo_s[k+1] <= {quo_s[k][FRAC_BITS-2:0], ge};
      sat_s[k+1] <= sat_s[k];
      neg_s[k+1] <= neg_s[k];
    end
  end

  logic             rnd;
  logic [FRAC_BITS:0] qr;
  logic [OUT_W-1:0] mag;
  logic [OUT_W-1:0] q_d;
  always_comb begin
    rnd = {rem_s[DIV_STEPS], 1'b0} >= {1'b0, den_s[DIV_STEPS]};
    qr  = {1'b0, quo_s[DIV_STEPS]} + (FRAC_BITS+1)'(rnd);
    mag = sat_s[DIV_STEPS] ? ONE_Q : OUT_W'(qr);
    q_d = neg_s[DIV_STEPS] ? OUT_W'(-mag) : mag;
  end

  always_ff @(posedge clk_i) begin
    q_o <= q_d;
  end
endmodule
`default_nettype wire

### hw/rtl/quaternion_to_rotation_matrix.sv
`default_nettype none
// done_o marks each result after input, product, sum, divider and rounding regs.
// Throughput: one item per cycle; busy_o is always low, the pipeline never stalls.
// Stages: input reg, ten 16x16 products, sums/norm, 14 divider steps, rounding.
// Reset (async, active low) clears only vld_q and deg_q; data regs are not reset.
// The receiver cannot stall: each result shows for one cycle with done_o.
module quaternion_to_rotation_matrix import q2r_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic signed [IN_W-1:0]  quat_x_i,
  input  wire logic signed [IN_W-1:0]  quat_y_i,
  input  wire logic signed [IN_W-1:0]  quat_z_i,
  input  wire logic signed [IN_W-1:0]  quat_w_i,
  output logic                         done_o,
  output logic signed [OUT_W-1:0]      r00_o,
  output logic signed [OUT_W-1:0]      r01_o,
  output logic signed [OUT_W-1:0]      r02_o,
  output logic signed [OUT_W-1:0]      r10_o,
  output logic signed [OUT_W-1:0]      r11_o,
  output logic signed [OUT_W-1:0]      r12_o,
  output logic signed [OUT_W-1:0]      r20_o,
  output logic signed [OUT_W-1:0]      r21_o,
  output logic signed [OUT_W-1:0]      r22_o,
  output logic                         degenerate_o
);
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // valid and zero-quaternion flag ride along with the data
  logic [LATENCY-1:0] vld_q, vld_d;
  logic [LATENCY-1:0] deg_q, deg_d;
  logic               is_zero;
  assign is_zero = (quat_x_i == '0) && (quat_y_i == '0) &&
                   (quat_z_i == '0) && (quat_w_i == '0);
  assign vld_d = {vld_q[LATENCY-2:0], accept};
  assign deg_d = {deg_q[LATENCY-2:0], is_zero};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      deg_q <= '0;
    end else begin
      vld_q <= vld_d;
      deg_q <= deg_d;
    end
  end

  // stage 1: input capture
  logic signed [IN_W-1:0] x_q, y_q, z_q, w_q;
  always_ff @(posedge clk_i) begin
    x_q <= quat_x_i;
    y_q <= quat_y_i;
    z_q <= quat_z_i;
    w_q <= quat_w_i;
  end

  // stage 2: products
  logic signed [PROD_W-1:0] xx_q, yy_q, zz_q, ww_q, xy_q, zw_q, xz_q, yw_q, yz_q, xw_q;
  always_ff @(posedge clk_i) begin
    xx_q <= x_q * x_q;
    yy_q <= y_q * y_q;
    zz_q <= z_q * z_q;
    ww_q <= w_q * w_q;
    xy_q <= x_q * y_q;
    zw_q <= z_q * w_q;
    xz_q <= x_q * z_q;
    yw_q <= y_q * w_q;
    yz_q <= y_q * z_q;
    xw_q <= x_q * w_q;
  end

  // stage 3: squared norm and numerators, split into sign and magnitude
  logic signed [NUM_W-1:0] xx_e, yy_e, zz_e, ww_e;
  logic signed [NUM_W-1:0] num [9];
  logic [DEN_W-1:0]        n2_d;
  always_comb begin
    xx_e = NUM_W'(xx_q);
    yy_e = NUM_W'(yy_q);
    zz_e = NUM_W'(zz_q);
    ww_e = NUM_W'(ww_q);
    n2_d = DEN_W'(xx_e + yy_e + zz_e + ww_e);
    num[0] = ww_e + xx_e - yy_e - zz_e;
    num[1] = (NUM_W'(xy_q) - NUM_W'(zw_q)) <<< 1;
    num[2] = (NUM_W'(xz_q) + NUM_W'(yw_q)) <<< 1;
    num[3] = (NUM_W'(xy_q) + NUM_W'(zw_q)) <<< 1;
    num[4] = ww_e - xx_e + yy_e - zz_e;
    num[5] = (NUM_W'(yz_q) - NUM_W'(xw_q)) <<< 1;
    num[6] = (NUM_W'(xz_q) - NUM_W'(yw_q)) <<< 1;
    num[7] = (NUM_W'(yz_q) + NUM_W'(xw_q)) <<< 1;
    num[8] = ww_e - xx_e - yy_e + zz_e;
  end

  logic [DEN_W-1:0] n2_q;
  logic [NUM_W-1:0] mag_q [9];
  logic             neg_q [9];
  logic             sat_q [9];
  logic [OUT_W-1:0] ent   [9];

  always_ff @(posedge clk_i) begin
    n2_q <= n2_d;
  end

  for (genvar i = 0; i < 9; i++) begin : g_lane
    logic [NUM_W-1:0] mag_d;
    assign mag_d = num[i][NUM_W-1] ? NUM_W'(-num[i]) : NUM_W'(num[i]);
    always_ff @(posedge clk_i) begin
      mag_q[i] <= mag_d;
      neg_q[i] <= num[i][NUM_W-1];
      sat_q[i] <= mag_d >= NUM_W'(n2_d);
    end
    q2r_div u_div (
      .clk_i (clk_i),
      .sat_i (sat_q[i]),
      .neg_i (neg_q[i]),
      .mag_i (mag_q[i]),
      .den_i (n2_q),
      .q_o   (ent[i])
    );
  end

  // zero quaternion: identity overrides the divider output
  logic deg;
  assign deg          = deg_q[LATENCY-1];
  assign done_o       = vld_q[LATENCY-1];
  assign degenerate_o = deg;
  assign r00_o = deg ? ONE_Q : ent[0];
  assign r01_o = deg ? '0    : ent[1];
  assign r02_o = deg ? '0    : ent[2];
  assign r10_o = deg ? '0    : ent[3];
  assign r11_o = deg ? ONE_Q : ent[4];
  assign r12_o = deg ? '0    : ent[5];
  assign r20_o = deg ? '0    : ent[6];
  assign r21_o = deg ? '0    : ent[7];
  assign r22_o = deg ? ONE_Q : ent[8];
endmodule
`default_nettype wire

### hw/rtl/q2r_checker.sv
`default_nettype none
module q2r_checker import q2r_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    start_i,
  input wire logic                    busy_o,
  input wire logic                    done_o,
  input wire logic signed [OUT_W-1:0] r00_o,
  input wire logic signed [OUT_W-1:0] r01_o,
  input wire logic signed [OUT_W-1:0] r11_o,
  input wire logic                    degenerate_o
);
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##18 done_o)
    else $error("result missing");
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 18))
    else $error("result without item");
  a_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (r00_o == ONE_Q && r11_o == ONE_Q && r01_o == '0))
    else $error("degenerate not identity");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (r01_o <= $signed(ONE_Q) && r01_o >= -$signed(ONE_Q)))
    else $error("entry out of range");
endmodule

bind quaternion_to_rotation_matrix q2r_checker u_q2r_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .r00_o        (r00_o),
  .r01_o        (r01_o),
  .r11_o        (r11_o),
  .degenerate_o (degenerate_o)
);
`default_nettype wire

### tb/sv/testbench.sv
module testbench;
  import q2r_pkg::*;

  typedef logic signed [IN_W-1:0]  comp_t;
  typedef logic signed [OUT_W-1:0] entry_t;

  // one expected rotation matrix plus the zero-quaternion flag
  typedef struct {
    entry_t r [9];
    logic   degenerate;
  } rot_matrix_t;

  logic   clk_i;
  logic   rst_ni;
  logic   start_i;
  comp_t  quat_x_i, quat_y_i, quat_z_i, quat_w_i;
  logic   busy_o, done_o, degenerate_o;
  entry_t r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o;

  rot_matrix_t pending_matrices[$];
  int unsigned fail_cnt = 0;
  bit          no_idle  = 0;

  quaternion_to_rotation_matrix dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .quat_x_i, .quat_y_i, .quat_z_i, .quat_w_i,
    .done_o,
    .r00_o, .r01_o, .r02_o, .r10_o, .r11_o, .r12_o, .r20_o, .r21_o, .r22_o,
    .degenerate_o
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // round(num * 2^FRAC_BITS / den) half away from zero, clamped to +-1.0
  function automatic entry_t ratio_q14(longint num, longint den);
    longint mag, q, r, one;
    mag = (num < 0) ? -num : num;
    one = longint'(1) << FRAC_BITS;
    if (mag >= den) begin
      q = one;
    end else begin
      q = (mag << FRAC_BITS) / den;
      r = (mag << FRAC_BITS) % den;
      if (2 * r >= den) q++;
      if (q > one) q = one;
    end
    return entry_t'((num < 0) ? -q : q);
  endfunction

  function automatic rot_matrix_t rotation_of(comp_t qx, comp_t qy, comp_t qz, comp_t qw);
    rot_matrix_t m;
    longint x, y, z, w, xx, yy, zz, ww, n2;
    longint num [9];
    x = qx; y = qy; z = qz; w = qw;
    if (x == 0 && y == 0 && z == 0 && w == 0) begin
      // zero quaternion: identity, flagged
      foreach (m.r[i]) m.r[i] = (i % 4 == 0) ? entry_t'(ONE_Q) : '0;
      m.degenerate = 1'b1;
      return m;
    end
    xx = x * x; yy = y * y; zz = z * z; ww = w * w;
    n2 = xx + yy + zz + ww;
    num[0] = ww + xx - yy - zz;
    num[1] = 2 * (x * y - z * w);
    num[2] = 2 * (x * z + y * w);
    num[3] = 2 * (x * y + z * w);
    num[4] = ww - xx + yy - zz;
    num[5] = 2 * (y * z - x * w);
    num[6] = 2 * (x * z - y * w);
    num[7] = 2 * (y * z + x * w);
    num[8] = ww - xx - yy + zz;
    foreach (num[i]) m.r[i] = ratio_q14(num[i], n2);
    m.degenerate = 1'b0;
    return m;
  endfunction

  // Drive one item; hold until accepted (start high, busy low at an edge).
  task automatic send_quat(comp_t qx, comp_t qy, comp_t qz, comp_t qw);
    int unsigned gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    quat_x_i <= qx;
    quat_y_i <= qy;
    quat_z_i <= qz;
    quat_w_i <= qw;
    do @(posedge clk_i); while (busy_o);
    pending_matrices.push_back(rotation_of(qx, qy, qz, qw));
  endtask

  // drop start right at the accepting edge so the last item is not taken twice, then wait until nothing is pending
  task automatic pause_sender();
    start_i <= 1'b0;
    while (pending_matrices.size() != 0) @(posedge clk_i);
  endtask

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0:       return comp_t'($urandom_range(0, 15)) - 8;      // tiny, near zero
      1:       return $urandom_range(0, 1) ? comp_t'(16'sh7fff) : comp_t'(16'sh8000);
      default: return comp_t'($urandom);
    endcase
  endfunction

  // Corners: zero quaternion, full-scale components, single axes, rotations.
  task automatic test_directed();
    send_quat(0, 0, 0, 0);
    send_quat(0, 0, 0, 16'sh7fff);
    send_quat(0, 0, 0, 16'sh8000);
    send_quat(16'sh7fff, 0, 0, 0);
    send_quat(0, 16'sh8000, 0, 0);
    send_quat(0, 0, 16'sh7fff, 0);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_quat(1, 0, 0, 0);
    send_quat(0, 0, 0, -1);
    send_quat(1, 1, 1, 1);
    send_quat(-1, 1, -1, 1);
    send_quat(16'sh5a82, 0, 0, 16'sh5a82);   // 90 deg about x
    send_quat(0, 16'sh5a82, 0, 16'sh5a82);
    send_quat(0, 0, -16'sh5a82, 16'sh5a82);
    send_quat(16'sh0001, 16'sh7fff, 0, 0);
    send_quat(3, 4, 0, 0);                   // tiny, non-unit scale
    send_quat(16'sh5555, 16'shaaaa, 16'sh1234, 16'shfedc);
    send_quat(0, 0, 0, 0);
  endtask

  task automatic test_random(int unsigned n);
    repeat (n) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  // Receiver: done_o marks one result for exactly one cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_matrices.size() == 0) begin
        $error("result with nothing pending");
        fail_cnt++;
      end else begin
        automatic rot_matrix_t exp_m = pending_matrices.pop_front();
        automatic entry_t got [9] = '{r00_o, r01_o, r02_o, r10_o, r11_o, r12_o,
                                      r20_o, r21_o, r22_o};
        foreach (got[i]) begin
          if (got[i] !== exp_m.r[i]) begin
            $error("r%0d%0d: expected %0d, got %0d", i / 3, i % 3, exp_m.r[i], got[i]);
            fail_cnt++;
          end
        end
        if (degenerate_o !== exp_m.degenerate) begin
          $error("degenerate: expected %0b, got %0b", exp_m.degenerate, degenerate_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    rst_ni   = 1'b0;
    start_i  = 1'b0;
    quat_x_i = '0;
    quat_y_i = '0;
    quat_z_i = '0;
    quat_w_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(500);
    pause_sender();
    test_random(400);
    // closing stretch at full rate
    no_idle = 1;
    test_random(200);
    start_i <= 1'b0;

    while (pending_matrices.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (fail_cnt == 0 && pending_matrices.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

### quaternion_to_rotation_matrix.f
hw/rtl/q2r_pkg.sv
hw/rtl/q2r_div.sv
hw/rtl/quaternion_to_rotation_matrix.sv
hw/rtl/q2r_checker.sv
tb/sv/testbench.sv
